[design/drpt_pkg.sv]
`default_nettype none
package drpt_pkg;

    localparam int POOL_TABLES          = 4;
    localparam int FIRST_LEVEL_ENTRIES  = 512;
    localparam int SECOND_LEVEL_ENTRIES = 512;

    localparam int L1_IDX_W   = $clog2(FIRST_LEVEL_ENTRIES);
    localparam int L2_IDX_W   = $clog2(SECOND_LEVEL_ENTRIES);
    localparam int TAB_W      = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int NFT_W      = $clog2(POOL_TABLES + 1);
    localparam int POOL_DEPTH = POOL_TABLES * SECOND_LEVEL_ENTRIES;
    localparam int POOL_AW    = TAB_W + L2_IDX_W;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_MAP  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_FOREIGN = 2'd2;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_LOW_SKIP  = 1'b1;

    localparam logic [9:0]  LOW_SKIP_RESET = 10'd4;
    localparam logic [20:0] DEV_BLOCK      = 21'h000401;
    localparam logic [11:0] TABLE_DESC     = 12'h003;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] phys_address;
        logic [47:0] range_size;
        logic [63:0] entry_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] first_level_value;
        logic [63:0] second_level_value;
        logic [2:0]  tables_in_use;
        logic        invalidate_request;
    } t_out;

    typedef struct packed {
        logic latch;
        logic clr_step;
        logic l1_rd_in;
        logic l1_rd_r;
        logic l1_wr_in;
        logic l1_wr_tab;
        logic pool_rd;
        logic cap_l1;
        logic cap_l2;
        logic split_step;
        logic blk_init;
        logic blk_step;
        logic next_region;
        logic use_found;
        logic set_full;
        logic set_foreign;
        logic set_inval;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] mode;
        logic       idx_ok;
        logic       size_zero;
        logic       region_end;
        logic       region_skip;
        logic       is_table;
        logic       found;
        logic       is_block;
        logic       pool_full;
        logic       cnt_last;
        logic       blk_last;
    } t_stat;

endpackage
`default_nettype wire

[design/drpt_ctrl.sv]
`default_nettype none
module drpt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire drpt_pkg::t_stat i_stat,
    output drpt_pkg::t_cmd      o_cmd,
    output logic                busy,
    output logic                o_done
);
    import drpt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_RD_L1, S_RD_L2, S_MAP_REGION,
        S_MAP_ENTRY, S_SPLIT, S_BLK_START, S_BLOCKS, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_done;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                if (i_stat.mode == MODE_LOAD) begin
                    o_cmd.l1_wr_in = i_stat.idx_ok;
                end else if (i_stat.mode == MODE_MAP) begin
                    if (!i_stat.size_zero) n_state = S_MAP_REGION;
                end else if (i_stat.mode == MODE_READ) begin
                    if (i_stat.idx_ok) begin
                        o_cmd.l1_rd_in = 1'b1;
                        n_state        = S_RD_L1;
                    end
                end
            end
            S_RD_L1: begin
                o_cmd.cap_l1 = 1'b1;
                n_state      = S_DONE;
                if (i_stat.is_table) begin
                    if (i_stat.found) begin
                        o_cmd.pool_rd = 1'b1;
                        n_state       = S_RD_L2;
                    end else begin
                        o_cmd.set_foreign = 1'b1;
                    end
                end
            end
            S_RD_L2: begin
                o_cmd.cap_l2 = 1'b1;
                n_state      = S_DONE;
            end
            S_MAP_REGION: begin
                if (i_stat.region_end) begin
                    o_cmd.set_inval = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.region_skip) begin
                    o_cmd.next_region = 1'b1;
                end else begin
                    o_cmd.l1_rd_r = 1'b1;
                    n_state       = S_MAP_ENTRY;
                end
            end
            S_MAP_ENTRY: begin
                if (i_stat.is_table) begin
                    if (i_stat.found) begin
                        o_cmd.use_found = 1'b1;
                        n_state         = S_BLK_START;
                    end else begin
                        o_cmd.set_foreign = 1'b1;
                        o_cmd.next_region = 1'b1;
                        n_state           = S_MAP_REGION;
                    end
                end else if (i_stat.pool_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.l1_wr_tab = 1'b1;
                    n_state         = i_stat.is_block ? S_SPLIT : S_BLK_START;
                end
            end
            S_SPLIT: begin
                o_cmd.split_step = 1'b1;
                if (i_stat.cnt_last) n_state = S_BLK_START;
            end
            S_BLK_START: begin
                o_cmd.blk_init = 1'b1;
                n_state        = S_BLOCKS;
            end
            S_BLOCKS: begin
                o_cmd.blk_step = 1'b1;
                if (i_stat.blk_last) begin
                    o_cmd.next_region = 1'b1;
                    n_state           = S_MAP_REGION;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (n_state == S_DONE);
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

endmodule
`default_nettype wire

[design/drpt_dp.sv]
`default_nettype none
module drpt_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire drpt_pkg::t_cmd  i_cmd,
    input  wire drpt_pkg::t_in   i_in,
    input  wire logic            i_cfg_valid,
    input  wire logic            i_cfg_index,
    input  wire logic [47:0]     i_cfg_data,
    output drpt_pkg::t_stat      o_stat,
    output drpt_pkg::t_out       o_result
);
    import drpt_pkg::*;

    logic [63:0] l1_mem   [FIRST_LEVEL_ENTRIES];
    logic [63:0] pool_mem [POOL_DEPTH];

    logic [47:0]         r_pba;
    logic [9:0]          r_low_skip;
    logic [NFT_W-1:0]    r_nft;
    logic [POOL_AW-1:0]  r_clr;

    logic [1:0]          r_mode;
    logic [47:0]         r_phys;
    logic                r_size_zero;
    logic [63:0]         r_entry_in;
    logic [26:0]         r_base_blk;
    logic [28:0]         r_end_blk;
    logic [17:0]         r_region;
    logic [L2_IDX_W-1:0] r_cnt;
    logic [TAB_W-1:0]    r_tab;
    logic                r_wrote;

    logic [63:0] r_l1_q, r_pool_q;
    logic [1:0]  r_status;
    logic [63:0] r_l1_val, r_l2_val;
    logic        r_inval;

    logic [49:0]         end_sum;
    logic [52:0]         diff;
    logic [TAB_W-1:0]    found_tab;
    logic [26:0]         region_blk;
    logic [28:0]         blk_next;
    logic [36:0]         new_tab_addr;
    logic [L1_IDX_W-1:0] l1_raddr;

    assign end_sum    = 50'(i_in.phys_address) + 50'(i_in.range_size) + 50'h1FFFFF;
    assign diff       = {1'b0, r_l1_q[63:12]} - {17'b0, r_pba[47:12]};
    assign found_tab  = diff[TAB_W-1:0];
    assign region_blk = {r_region, {L2_IDX_W{1'b0}}};
    assign blk_next   = 29'({r_region[L1_IDX_W-1:0], r_cnt}) + 29'd1;
    assign new_tab_addr = 37'(r_pba[47:12]) + 37'(r_nft);
    assign l1_raddr   = i_cmd.l1_rd_r ? r_region[L1_IDX_W-1:0] : r_phys[38:30];

    always_comb begin
        o_stat             = '0;
        o_stat.clr_last    = (r_clr == POOL_AW'(POOL_DEPTH - 1));
        o_stat.mode        = r_mode;
        o_stat.idx_ok      = (r_phys[47:39] == '0);
        o_stat.size_zero   = r_size_zero;
        o_stat.region_end  = (r_region >= 18'(FIRST_LEVEL_ENTRIES)) ||
                             (29'(region_blk) >= r_end_blk);
        o_stat.region_skip = (r_region < 18'(r_low_skip));
        o_stat.is_table    = (r_l1_q[1:0] == TABLE_DESC[1:0]);
        o_stat.found       = !diff[52] && (diff[51:0] < 52'(r_nft));
        o_stat.is_block    = r_l1_q[0];
        o_stat.pool_full   = (r_nft >= NFT_W'(POOL_TABLES));
        o_stat.cnt_last    = (r_cnt == '1);
        o_stat.blk_last    = (blk_next >= r_end_blk) || (r_cnt == '1);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pba      <= '0;
            r_low_skip <= LOW_SKIP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_POOL_BASE) r_pba <= i_cfg_data;
            else r_low_skip <= i_cfg_data[9:0];
        end
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_nft <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.l1_wr_tab) r_nft <= r_nft + 1'b1;
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode      <= i_in.mode;
            r_phys      <= i_in.phys_address;
            r_size_zero <= (i_in.range_size == '0);
            r_entry_in  <= i_in.entry_value;
            r_base_blk  <= i_in.phys_address[47:21];
            r_end_blk   <= end_sum[49:21];
            r_region    <= i_in.phys_address[47:30];
            r_wrote     <= 1'b0;
            r_status    <= ST_OK;
            r_l1_val    <= '0;
            r_l2_val    <= '0;
            r_inval     <= 1'b0;
        end
        if (i_cmd.next_region) r_region <= r_region + 1'b1;
        if (i_cmd.use_found) r_tab <= found_tab;
        if (i_cmd.l1_wr_tab) begin
            r_tab   <= TAB_W'(r_nft);
            r_cnt   <= '0;
            r_wrote <= 1'b1;
        end
        if (i_cmd.split_step) r_cnt <= r_cnt + 1'b1;
        if (i_cmd.blk_init) begin
            r_cnt <= (r_base_blk > region_blk) ? r_base_blk[L2_IDX_W-1:0] : '0;
        end
        if (i_cmd.blk_step) begin
            r_cnt   <= r_cnt + 1'b1;
            r_wrote <= 1'b1;
        end
        if (i_cmd.set_foreign) r_status <= ST_FOREIGN;
        if (i_cmd.set_full) begin
            r_status <= ST_FULL;
            r_inval  <= r_wrote;
        end
        if (i_cmd.set_inval) r_inval <= 1'b1;
        if (i_cmd.cap_l1) r_l1_val <= r_l1_q;
        if (i_cmd.cap_l2) r_l2_val <= r_pool_q;
    end

    // first-level table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            l1_mem[r_clr[L1_IDX_W-1:0]] <= '0;
        end else if (i_cmd.l1_wr_in) begin
            l1_mem[r_phys[38:30]] <= r_entry_in;
        end else if (i_cmd.l1_wr_tab) begin
            l1_mem[r_region[L1_IDX_W-1:0]] <= {15'b0, new_tab_addr, TABLE_DESC};
        end
        if (i_cmd.l1_rd_in || i_cmd.l1_rd_r) r_l1_q <= l1_mem[l1_raddr];
    end

    // second-level pool
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            pool_mem[r_clr] <= '0;
        end else if (i_cmd.split_step) begin
            pool_mem[{r_tab, r_cnt}] <= {r_l1_q[63:30], r_cnt, 9'b0, r_l1_q[11:0]};
        end else if (i_cmd.blk_step) begin
            pool_mem[{r_tab, r_cnt}] <= {25'b0, r_region[L1_IDX_W-1:0], r_cnt, DEV_BLOCK};
        end
        if (i_cmd.pool_rd) r_pool_q <= pool_mem[{found_tab, r_phys[29:21]}];
    end

    assign o_result.status             = r_status;
    assign o_result.first_level_value  = r_l1_val;
    assign o_result.second_level_value = r_l2_val;
    assign o_result.tables_in_use      = 3'(r_nft);
    assign o_result.invalidate_request = r_inval;

endmodule
`default_nettype wire

[design/device_range_page_table_mapper_unit.sv]
`default_nettype none
// Device range page table mapper. After reset the block is busy for a clearing
// pass that zeroes the first-level table and the second-level pool, one entry
// per cycle. A command is a transfer at a clock edge with start high and busy
// low; its one result appears on o_result for exactly one cycle with o_done
// high, and must be taken then, since the receiver cannot stall.
// A load, an unused mode or a map of zero length finishes from the decode
// state; a read also reads the first-level entry and, for a table descriptor
// found in the pool, the pool entry. Any other map walks the 1GB regions in
// range: a region is skipped or has its descriptor looked up, a prior 1GB
// block there is split into a new pool table, and each 2MB block in range is
// written: the single-ported pool memory writes one descriptor per cycle. A
// map that runs out of pool tables ends at that region.
// Configuration writes are accepted at any time but belong in idle periods.
module device_range_page_table_mapper_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire drpt_pkg::t_in i_in,
    output logic               o_done,
    output drpt_pkg::t_out     o_result,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [47:0]   i_cfg_data
);
    import drpt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // registers take every write transfer in the cycle it is offered
    assign o_cfg_ready = 1'b1;

    drpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    drpt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_result    (o_result)
    );

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held more than one cycle");

    // an accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after transfer");

    // pool allocation never passes the pool size
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.tables_in_use <= 3'(POOL_TABLES)) else $error("pool overrun");

    // status code is a defined one
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status <= ST_FOREIGN)) else $error("undefined status");

endmodule
`default_nettype wire
